@@ rtl/dflm_pkg.sv @@
// Shared types and constants for the descriptor free-list manager.
// No dependencies; imported by every module of the block.
package dflm_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int SIZE_CAP    = (MAX_ENTRIES < 256) ? MAX_ENTRIES : 256;
  localparam int ADDR_W      = (SIZE_CAP > 1) ? $clog2(SIZE_CAP) : 1;

  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;
  localparam int ENT_W   = IDX_W + 1;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 2;

  localparam logic [PADDR_W-1:0] REG_QUEUE_SIZE = 2'd0;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_CHAIN = 2'd2;
  localparam logic [1:0] REQ_LINK  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CHAIN,
    OP_LINK,
    OP_REJECT
  } dflm_op_t;

  typedef struct packed {
    dflm_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  lnext;
    logic              lmark;
  } dflm_req_t;

  typedef struct packed {
    logic      valid;
    dflm_req_t req;
  } dflm_qif_t;

  typedef struct packed {
    logic             rebuild;
    logic [CNT_W-1:0] size;
  } dflm_cfg_t;

endpackage

@@ rtl/dflm_front.sv @@
// Front end: accepts requests, classifies them and queues them for the engine.
// Depends on dflm_pkg.
module dflm_front
  import dflm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] qsize,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_req_type,
  input  logic [IDX_W-1:0] in_desc_index,
  input  logic [IDX_W-1:0] in_link_next,
  input  logic             in_link_has_next,
  output dflm_qif_t        q_out,
  input  logic             q_pop
);

  dflm_req_t         fifo_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  dflm_req_t         cls;

  always_comb begin
    cls.idx   = in_desc_index;
    cls.lnext = in_link_next;
    cls.lmark = in_link_has_next;
    priority if (in_req_type == REQ_ALLOC) begin
      cls.op = OP_ALLOC;
    end else if ({1'b0, in_desc_index} >= qsize) begin
      cls.op = OP_REJECT;
    end else if (in_req_type == REQ_FREE) begin
      cls.op = OP_FREE;
    end else if (in_req_type == REQ_CHAIN) begin
      cls.op = OP_CHAIN;
    end else begin
      cls.op = OP_LINK;
    end
  end

  assign in_stall      = (cnt_r == QCNT_W'(QDEPTH));
  assign push          = in_valid && !in_stall;
  assign pop           = q_pop && (cnt_r != '0);
  assign q_out.valid   = (cnt_r != '0);
  assign q_out.req     = fifo_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) && !push |=> (cnt_r == '0))
    else $error("queue count moved without a push");

  a_full_next: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + QCNT_W'(1))
    else $error("queue count missed a push");

endmodule

@@ rtl/dflm_back.sv @@
// Back end: executes queued requests on the descriptor table, holds list
// head and free count, and drives the result register. Depends on dflm_pkg.
module dflm_back
  import dflm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] qsize,
  input  dflm_cfg_t        cfg,
  input  dflm_qif_t        q_in,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [IDX_W-1:0] out_granted_index,
  output logic [CNT_W-1:0] out_free_left
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_ISS  = 4'b0100,
    S_RESP = 4'b1000
  } bst_t;

  bst_t             state_r, state_nxt;
  dflm_op_t         op_r, op_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [1:0]       rst_status_r, rst_status_nxt;
  logic [IDX_W-1:0] grant_r, grant_nxt;

  logic [ENT_W-1:0] mem_r [SIZE_CAP];
  logic [SIZE_CAP-1:0] vld_r;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_addr_r;

  logic [IDX_W-1:0] dflt_next;
  logic [IDX_W-1:0] eff_next;
  logic             eff_mark;
  logic [CNT_W-1:0] total_inc;
  logic             out_free;
  logic             out_valid_r;

  // Table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[ADDR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr[ADDR_W-1:0]];
      rd_addr_r <= rd_addr;
      rd_vld_r  <= vld_r[rd_addr[ADDR_W-1:0]];
    end
  end

  // Unwritten entries read as the rebuilt list
  always_ff @(posedge clk) begin
    if (!rst_n || cfg.rebuild) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr[ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    dflt_next = (({1'b0, rd_addr_r} + CNT_W'(1)) < qsize) ? rd_addr_r + IDX_W'(1) : '0;
    eff_next  = rd_vld_r ? rd_data_r[IDX_W-1:0] : dflt_next;
    eff_mark  = rd_vld_r && rd_data_r[IDX_W];
    total_inc = (total_r < qsize) ? total_r + CNT_W'(1) : total_r;
    out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    head_nxt       = head_r;
    total_nxt      = total_r;
    rst_status_nxt = rst_status_r;
    grant_nxt      = grant_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_in.valid) begin
          q_pop          = 1'b1;
          op_nxt         = q_in.req.op;
          rst_status_nxt = ST_OK;
          grant_nxt      = '0;
          state_nxt      = S_RESP;
          unique case (q_in.req.op)
            OP_REJECT: begin
              rst_status_nxt = ST_RANGE;
            end
            OP_FREE: begin
              wr_en     = 1'b1;
              wr_addr   = q_in.req.idx;
              wr_data   = {1'b0, head_r};
              head_nxt  = q_in.req.idx;
              total_nxt = total_inc;
            end
            OP_LINK: begin
              wr_en   = 1'b1;
              wr_addr = q_in.req.idx;
              wr_data = {q_in.req.lmark, q_in.req.lnext};
            end
            OP_ALLOC: begin
              priority if (total_r == '0) begin
                rst_status_nxt = ST_EMPTY;
              end else if ({1'b0, head_r} >= qsize) begin
                rst_status_nxt = ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                cur_nxt   = head_r;
                state_nxt = S_RD;
              end
            end
            OP_CHAIN: begin
              rd_en     = 1'b1;
              rd_addr   = q_in.req.idx;
              cur_nxt   = q_in.req.idx;
              steps_nxt = '0;
              state_nxt = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        if (op_r == OP_ALLOC) begin
          wr_data   = '0;
          head_nxt  = eff_next;
          total_nxt = total_r - CNT_W'(1);
          grant_nxt = cur_r;
          state_nxt = S_RESP;
        end else begin
          wr_data   = {1'b0, head_r};
          head_nxt  = cur_r;
          total_nxt = total_inc;
          priority if (!eff_mark) begin
            state_nxt = S_RESP;
          end else if ({1'b0, eff_next} >= qsize) begin
            rst_status_nxt = ST_RANGE;
            state_nxt      = S_RESP;
          end else if ((steps_r + CNT_W'(1)) >= qsize) begin
            state_nxt = S_RESP;
          end else begin
            cur_nxt   = eff_next;
            steps_nxt = steps_r + CNT_W'(1);
            state_nxt = S_ISS;
          end
        end
      end
      S_ISS: begin
        rd_en     = 1'b1;
        rd_addr   = cur_r;
        state_nxt = S_RD;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      total_r <= CNT_W'(SIZE_CAP);
    end else if (cfg.rebuild) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      total_r <= cfg.size;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    rst_status_r <= rst_status_nxt;
    grant_r      <= grant_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_free) begin
      out_status        <= rst_status_r;
      out_granted_index <= grant_r;
      out_free_left     <= total_r;
    end
  end

  assign out_valid = out_valid_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= qsize)
    else $error("free count above queue size");

  a_rd_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> $past(rd_en))
    else $error("table data used without a read");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_valid_r && out_stall |=> (state_r == S_RESP))
    else $error("result dropped while output stalled");

  a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_in.valid && (q_in.req.op == OP_FREE) && !cfg.rebuild
    |=> head_r == $past(q_in.req.idx))
    else $error("freed entry not at list head");

endmodule

@@ rtl/descriptor_free_list_manager_core.sv @@
// Top level of the descriptor free-list manager: config register, front end
// and back end. Depends on dflm_pkg, dflm_front and dflm_back.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | req_type, desc_index, link_next, link_has_next
//   out_    | output    | out_valid / out_stall| status, granted_index, free_left
//   config  | APB       | psel/penable/pready  | queue_size at byte address 0
//
// Free, link and refused requests go from idle straight to the result
// state; allocate first reads the head entry, and a chain free reads and
// pushes each entry onto the list in turn. A 2-entry queue takes requests
// while the engine works. Reset is synchronous and rebuilds the list at
// once; a queue_size write does the same. Output stall only holds the
// result register and the engine behind it.
module descriptor_free_list_manager_core
  import dflm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [IDX_W-1:0]   in_desc_index,
  input  logic [IDX_W-1:0]   in_link_next,
  input  logic               in_link_has_next,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_granted_index,
  output logic [CNT_W-1:0]   out_free_left
);

  logic [CNT_W-1:0] qsize_r, qsize_nxt;
  logic             wr_hit;
  dflm_cfg_t        cfg;
  dflm_qif_t        qif;
  logic             q_pop;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == REG_QUEUE_SIZE);
  assign prdata = {{(DATA_W-CNT_W){1'b0}}, qsize_r};

  always_comb begin
    priority if (pwdata[CNT_W-1:0] == '0) begin
      qsize_nxt = CNT_W'(1);
    end else if (pwdata[CNT_W-1:0] > CNT_W'(SIZE_CAP)) begin
      qsize_nxt = CNT_W'(SIZE_CAP);
    end else begin
      qsize_nxt = pwdata[CNT_W-1:0];
    end
    cfg.rebuild = wr_hit;
    cfg.size    = qsize_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsize_r <= CNT_W'(SIZE_CAP);
    end else if (wr_hit) begin
      qsize_r <= qsize_nxt;
    end
  end

  dflm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .qsize            (qsize_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_desc_index    (in_desc_index),
    .in_link_next     (in_link_next),
    .in_link_has_next (in_link_has_next),
    .q_out            (qif),
    .q_pop            (q_pop)
  );

  dflm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .qsize             (qsize_r),
    .cfg               (cfg),
    .q_in              (qif),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_left     (out_free_left)
  );

endmodule

@@ dv/free_list_scoreboard.sv @@
`timescale 1ns / 100ps
// Scoreboard for the descriptor free-list manager: a cycle-free model of the
// descriptor table, free list head and count, plus the queue of awaited results.
// Depends on dflm_pkg.
package free_list_check_pkg;
  import dflm_pkg::*;

  typedef struct {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] free_left;
  } outcome_t;

  class free_list_scoreboard;
    logic [IDX_W-1:0] link_tbl [SIZE_CAP];
    bit               mark_tbl [SIZE_CAP];
    bit               held     [SIZE_CAP];
    int unsigned      head;
    int unsigned      free_cnt;
    int unsigned      qsize;
    outcome_t         awaited [$];
    int               errors;

    function new();
      errors = 0;
      qsize = SIZE_CAP;
      rebuild();
    endfunction

    function void rebuild();
      for (int i = 0; i < SIZE_CAP; i++) begin
        link_tbl[i] = (i + 1 < qsize) ? IDX_W'(i + 1) : '0;
        mark_tbl[i] = 0;
        held[i] = 0;
      end
      head = 0;
      free_cnt = qsize;
    endfunction

    function void set_size(logic [DATA_W-1:0] value);
      int unsigned v;
      v = value & 32'h1FF;
      if (v < 1) v = 1;
      if (v > SIZE_CAP) v = SIZE_CAP;
      qsize = v;
      rebuild();
    endfunction

    function void push(int unsigned idx);
      link_tbl[idx] = IDX_W'(head);
      mark_tbl[idx] = 0;
      held[idx] = 0;
      head = idx;
      if (free_cnt < qsize) free_cnt++;
    endfunction

    // Runs one accepted request through the model and queues its result.
    function void note_request(logic [1:0] kind, logic [IDX_W-1:0] idx,
                               logic [IDX_W-1:0] lnext, logic lmark);
      outcome_t    res;
      int unsigned cur;
      int unsigned nxt;
      bit          more;
      res.status = ST_OK;
      res.granted = '0;
      if (kind == REQ_ALLOC) begin
        if (free_cnt == 0) begin
          res.status = ST_EMPTY;
        end else if (head >= qsize) begin
          res.status = ST_RANGE;
        end else begin
          res.granted = IDX_W'(head);
          head = link_tbl[res.granted];
          free_cnt--;
          link_tbl[res.granted] = '0;
          mark_tbl[res.granted] = 0;
          held[res.granted] = 1;
        end
      end else if (idx >= qsize) begin
        res.status = ST_RANGE;
      end else begin
        case (kind)
          REQ_FREE: begin
            push(idx);
          end
          REQ_CHAIN: begin
            cur = idx;
            for (int unsigned steps = 0; steps < qsize; steps++) begin
              nxt = link_tbl[cur];
              more = mark_tbl[cur];
              push(cur);
              if (!more) break;
              if (nxt >= qsize) begin
                res.status = ST_RANGE;
                break;
              end
              cur = nxt;
            end
          end
          default: begin
            link_tbl[idx] = lnext;
            mark_tbl[idx] = lmark;
          end
        endcase
      end
      res.free_left = CNT_W'(free_cnt);
      awaited.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [IDX_W-1:0] granted,
                               logic [CNT_W-1:0] free_left);
      outcome_t exp_res;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status %0d granted %0d free_left %0d",
                 $time, status, granted, free_left);
        errors++;
        return;
      end
      exp_res = awaited.pop_front();
      if (status !== exp_res.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
        errors++;
      end
      if (granted !== exp_res.granted) begin
        $display("%0t: granted_index expected %0d actual %0d",
                 $time, exp_res.granted, granted);
        errors++;
      end
      if (free_left !== exp_res.free_left) begin
        $display("%0t: free_left expected %0d actual %0d",
                 $time, exp_res.free_left, free_left);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // An entry currently handed out, or any in-range index if none is.
    function logic [IDX_W-1:0] pick_held();
      int unsigned cand [$];
      for (int i = 0; i < SIZE_CAP; i++)
        if (held[i]) cand.push_back(i);
      if (cand.size() == 0) return IDX_W'($urandom_range(qsize - 1));
      return IDX_W'(cand[$urandom_range(cand.size() - 1)]);
    endfunction
  endclass

endpackage

@@ dv/descriptor_free_list_manager_core_test.sv @@
`timescale 1ns / 100ps
// Top-level test for descriptor_free_list_manager_core: directed and random
// allocate/free/chain/link traffic over several queue sizes, random stalls.
// Depends on dflm_pkg and free_list_check_pkg.
module descriptor_free_list_manager_core_test;
  import dflm_pkg::*;
  import free_list_check_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_req_type;
  logic [IDX_W-1:0]   in_desc_index;
  logic [IDX_W-1:0]   in_link_next;
  logic               in_link_has_next;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic [IDX_W-1:0]   out_granted_index;
  logic [CNT_W-1:0]   out_free_left;

  free_list_scoreboard sb;
  bit calm;

  descriptor_free_list_manager_core DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send(logic [1:0] kind, logic [IDX_W-1:0] idx,
                      logic [IDX_W-1:0] lnext, logic lmark);
    in_valid <= 1;
    in_req_type <= kind;
    in_desc_index <= idx;
    in_link_next <= lnext;
    in_link_has_next <= lmark;
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, idx, lnext, lmark);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_queue_size(logic [DATA_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= REG_QUEUE_SIZE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_size(value);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send_chain();
    logic [IDX_W-1:0] ids [4];
    int               k;
    k = $urandom_range(1, 4);
    for (int j = 0; j < k; j++) ids[j] = sb.pick_held();
    for (int j = 0; j + 1 < k; j++) send(REQ_LINK, ids[j], ids[j + 1], 1);
    if ($urandom_range(9) == 0)
      send(REQ_LINK, ids[k - 1], IDX_W'($urandom_range(255)), 1);
    else
      send(REQ_LINK, ids[k - 1], IDX_W'($urandom_range(255)), 0);
    send(REQ_CHAIN, ids[0], IDX_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic run_random(int n);
    int sent;
    int r;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        send(REQ_ALLOC, IDX_W'($urandom_range(255)), IDX_W'($urandom_range(255)),
             1'($urandom_range(1)));
        sent++;
      end else if (r < 55) begin
        if ($urandom_range(9) == 0)
          send(REQ_FREE, IDX_W'($urandom_range(255)), IDX_W'($urandom_range(255)),
               1'($urandom_range(1)));
        else
          send(REQ_FREE, sb.pick_held(), IDX_W'($urandom_range(255)),
               1'($urandom_range(1)));
        sent++;
      end else if (r < 75) begin
        send_chain();
        sent += 3;
      end else if (r < 85) begin
        send(REQ_LINK, IDX_W'($urandom_range(255)), IDX_W'($urandom_range(255)),
             1'($urandom_range(1)));
        sent++;
      end else begin
        send(2'($urandom_range(3)), IDX_W'($urandom_range(255)),
             IDX_W'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // Result side: random stalls, plus a long hold-off now and then to back up the input.
  initial begin
    int seen;
    int hold;
    seen = 0;
    hold = 0;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_status, out_granted_index, out_free_left);
        seen++;
        if (seen % 250 == 120) hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 8);
      end
    end
  end

  initial begin
    sb = new();
    calm = 0;
    rst_n <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 0;
    in_req_type <= REQ_ALLOC;
    in_desc_index <= '0;
    in_link_next <= '0;
    in_link_has_next <= 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // full-size table after reset
    send(REQ_ALLOC, 8'h00, 8'h00, 0);
    send(REQ_ALLOC, 8'hFF, 8'hFF, 1);
    send(REQ_FREE, 8'hFF, 8'h00, 0);
    send(REQ_LINK, 8'h00, 8'h01, 1);
    send(REQ_LINK, 8'h01, 8'hAA, 0);
    send(REQ_CHAIN, 8'h00, 8'h00, 0);
    send(REQ_FREE, 8'h00, 8'h55, 1);
    send(REQ_LINK, 8'hFF, 8'hFF, 1);
    send(REQ_ALLOC, 8'h00, 8'h00, 0);

    // size field of zero saturates to one entry
    write_queue_size(32'hFFFF_FE00);
    send(REQ_FREE, 8'h01, 8'h00, 0);
    send(REQ_ALLOC, 8'h00, 8'h00, 0);
    send(REQ_ALLOC, 8'h00, 8'h00, 0);
    send(REQ_LINK, 8'h00, 8'h00, 1);
    send(REQ_CHAIN, 8'h00, 8'h00, 0);

    // corrupt head, bad chain link, chain cut off at queue_size steps, full count
    write_queue_size(32'd4);
    send(REQ_LINK, 8'h00, 8'd200, 0);
    send(REQ_ALLOC, 8'h00, 8'h00, 0);
    send(REQ_ALLOC, 8'h00, 8'h00, 0);
    send(REQ_LINK, 8'h01, 8'h02, 1);
    send(REQ_LINK, 8'h02, 8'h09, 1);
    send(REQ_CHAIN, 8'h01, 8'h00, 0);
    send(REQ_LINK, 8'h00, 8'h01, 1);
    send(REQ_LINK, 8'h01, 8'h02, 1);
    send(REQ_LINK, 8'h02, 8'h03, 1);
    send(REQ_LINK, 8'h03, 8'h00, 1);
    send(REQ_CHAIN, 8'h00, 8'h00, 0);
    send(REQ_FREE, 8'h03, 8'h00, 0);

    write_queue_size(32'h0000_01FF);
    run_random(70);
    write_queue_size(32'd2);
    run_random(70);
    write_queue_size(32'd8);
    run_random(75);
    write_queue_size(32'($urandom_range(1, 256)));
    calm = 1;
    run_random(75);
    calm = 0;
    write_queue_size(32'd256);
    run_random(75);
    write_queue_size(32'd3);
    run_random(70);
    write_queue_size(32'd16);
    run_random(75);
    write_queue_size(32'($urandom_range(257, 511)));
    run_random(75);
    write_queue_size(32'd1);
    run_random(60);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ descriptor_free_list_manager_core.f @@
rtl/dflm_pkg.sv
rtl/dflm_front.sv
rtl/dflm_back.sv
rtl/descriptor_free_list_manager_core.sv
dv/free_list_scoreboard.sv
dv/descriptor_free_list_manager_core_test.sv
